>>> hw/rtl/ecmc_pkg.sv
// ----------------------------------------------------------------------------
// ecmc_pkg
// Types and constants shared by the elevator car mode controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ecmc_pkg;

    localparam int TIME_W  = 32;
    localparam int FLOOR_W = 8;
    localparam int FAULT_W = 8;
    localparam int SHOW_W  = 4;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    localparam logic [TIME_W-1:0] TRAVEL_MS_RST = 32'd1000;
    localparam logic [TIME_W-1:0] HOLD_MS_RST   = 32'd2000;

    typedef enum logic [0:0] {
        CFG_FLOOR_TRAVEL = 1'b0,
        CFG_DOOR_HOLD    = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REQ_ASSIGN      = 2'd0,
        REQ_SET_FAULT   = 2'd1,
        REQ_CLEAR_FAULT = 2'd2,
        REQ_TICK        = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_MOVING = 2'd1,
        MODE_DOOR   = 2'd2,
        MODE_FAULT  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        MOT_IDLE = 2'd0,
        MOT_UP   = 2'd1,
        MOT_DOWN = 2'd2
    } t_motion;

    typedef struct packed {
        logic [TIME_W-1:0] travel_ms;
        logic [TIME_W-1:0] hold_ms;
    } t_cfg;

    typedef struct packed {
        t_req               req_type;
        logic [FLOOR_W-1:0] dest_floor;
        logic [FAULT_W-1:0] fault_id;
        logic [TIME_W-1:0]  now_ms;
    } t_event;

    typedef struct packed {
        logic [SHOW_W-1:0]  car_floor;
        t_motion            car_motion;
        t_mode              car_mode;
        logic               door_open;
        logic [FAULT_W-1:0] fault_status;
    } t_status;

endpackage

`default_nettype wire

>>> hw/rtl/ecmc_cfg_regs.sv
// ----------------------------------------------------------------------------
// ecmc_cfg_regs
// Travel time and door hold time registers behind the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module ecmc_cfg_regs
    import ecmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire t_cfg_idx          i_cfg_index,
    input  wire logic [TIME_W-1:0] i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.travel_ms <= TRAVEL_MS_RST;
            r_cfg.hold_ms   <= HOLD_MS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FLOOR_TRAVEL: r_cfg.travel_ms <= i_cfg_data;
                CFG_DOOR_HOLD:    r_cfg.hold_ms   <= i_cfg_data;
                default:          r_cfg           <= r_cfg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ecmc_in_stage.sv
// ----------------------------------------------------------------------------
// ecmc_in_stage
// Input register holding one event until the car state can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module ecmc_in_stage
    import ecmc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_event i_event,
    input  wire logic   i_advance,
    output logic        o_valid,
    output t_event      o_event
);

    logic   r_valid;
    t_event r_event;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_event = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_event <= i_event;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ecmc_core.sv
// ----------------------------------------------------------------------------
// ecmc_core
// Car state registers and the single-pass event update with status output.
// ----------------------------------------------------------------------------
`default_nettype none

module ecmc_core
    import ecmc_pkg::*;
#(
    parameter int TOP_FLOOR = 15
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_fire,
    input  wire t_event i_event,
    input  wire t_cfg   i_cfg,
    output t_status     o_status
);

    localparam int LVL_W = $clog2(TOP_FLOOR + 1);
    localparam logic [LVL_W-1:0]   LVL_TOP   = LVL_W'(TOP_FLOOR);
    localparam logic [FLOOR_W-1:0] FLOOR_TOP = FLOOR_W'(TOP_FLOOR);

    logic [LVL_W-1:0]   r_cur,  n_cur;
    logic [LVL_W-1:0]   r_goal, n_goal;
    t_motion            r_dir,  n_dir;
    t_mode              r_mode, n_mode;
    logic               r_door, n_door;
    logic [FAULT_W-1:0] r_fault, n_fault;
    logic [TIME_W-1:0]  r_step_t, n_step_t;
    logic [TIME_W-1:0]  r_open_t, n_open_t;

    logic [TIME_W-1:0] step_elapsed;
    logic [TIME_W-1:0] door_elapsed;
    logic [LVL_W-1:0]  clamp_goal;
    logic [LVL_W-1:0]  step_cur;

    assign step_elapsed = i_event.now_ms - r_step_t;
    assign door_elapsed = i_event.now_ms - r_open_t;
    assign clamp_goal   = (i_event.dest_floor > FLOOR_TOP) ? LVL_TOP
                                                           : LVL_W'(i_event.dest_floor);

    always_comb begin
        step_cur = r_cur;
        if (r_dir == MOT_UP && r_cur < LVL_TOP) begin
            step_cur = r_cur + 1'b1;
        end else if (r_dir == MOT_DOWN && r_cur != '0) begin
            step_cur = r_cur - 1'b1;
        end
    end

    // next state
    always_comb begin
        n_cur    = r_cur;
        n_goal   = r_goal;
        n_dir    = r_dir;
        n_mode   = r_mode;
        n_door   = r_door;
        n_fault  = r_fault;
        n_step_t = r_step_t;
        n_open_t = r_open_t;
        if (i_fire) begin
            unique case (i_event.req_type)
                REQ_ASSIGN: begin
                    if (r_mode != MODE_FAULT) begin
                        n_goal = clamp_goal;
                        if (r_cur < clamp_goal) begin
                            n_dir  = MOT_UP;
                            n_mode = MODE_MOVING;
                            n_door = 1'b0;
                        end else if (r_cur > clamp_goal) begin
                            n_dir  = MOT_DOWN;
                            n_mode = MODE_MOVING;
                            n_door = 1'b0;
                        end else begin
                            n_dir  = MOT_IDLE;
                            n_mode = MODE_DOOR;
                            n_door = 1'b1;
                        end
                    end
                end
                REQ_SET_FAULT: begin
                    n_mode  = MODE_FAULT;
                    n_fault = i_event.fault_id;
                    n_dir   = MOT_IDLE;
                    n_door  = 1'b0;
                end
                REQ_CLEAR_FAULT: begin
                    if (r_mode == MODE_FAULT) begin
                        n_fault = '0;
                        n_mode  = MODE_IDLE;
                    end
                end
                REQ_TICK: begin
                    if (r_mode == MODE_MOVING && step_elapsed >= i_cfg.travel_ms) begin
                        n_step_t = i_event.now_ms;
                        n_cur    = step_cur;
                        if (step_cur < r_goal) begin
                            n_dir = MOT_UP;
                        end else if (step_cur > r_goal) begin
                            n_dir = MOT_DOWN;
                        end else begin
                            n_dir    = MOT_IDLE;
                            n_mode   = MODE_DOOR;
                            n_door   = 1'b1;
                            n_open_t = i_event.now_ms;
                        end
                    end else if (r_mode == MODE_DOOR && door_elapsed >= i_cfg.hold_ms) begin
                        n_door = 1'b0;
                        n_mode = MODE_IDLE;
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    // status after the event
    always_comb begin
        o_status.car_floor    = SHOW_W'(n_cur);
        o_status.car_motion   = n_dir;
        o_status.car_mode     = n_mode;
        o_status.door_open    = n_door;
        o_status.fault_status = n_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= '0;
            r_goal   <= '0;
            r_dir    <= MOT_IDLE;
            r_mode   <= MODE_IDLE;
            r_door   <= 1'b0;
            r_fault  <= '0;
            r_step_t <= '0;
            r_open_t <= '0;
        end else begin
            r_cur    <= n_cur;
            r_goal   <= n_goal;
            r_dir    <= n_dir;
            r_mode   <= n_mode;
            r_door   <= n_door;
            r_fault  <= n_fault;
            r_step_t <= n_step_t;
            r_open_t <= n_open_t;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ecmc_out_stage.sv
// ----------------------------------------------------------------------------
// ecmc_out_stage
// Status result register toward the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module ecmc_out_stage
    import ecmc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_status i_status,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_status      o_status
);

    logic    r_valid;
    t_status r_status;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_status = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_status <= i_status;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/elevator_car_mode_controller.sv
// ----------------------------------------------------------------------------
// elevator_car_mode_controller
// Single elevator car mode controller with stream event input and status out.
// ----------------------------------------------------------------------------
// Takes one event per clock unless the output stalls (assign target, set
// fault, clear fault, time tick) and returns one status transaction per event,
// showing the car after the event. An event goes through the input register,
// one pass of update logic (two 32-bit elapsed-time subtracts and compares)
// and the status register; a stalled output holds back input only once both
// registers are full. The user must write travel and door hold times through
// the configuration channel only while no event is in flight; the block does
// not enforce this. Targets above TOP_FLOOR are clamped.
`default_nettype none

module elevator_car_mode_controller
    import ecmc_pkg::*;
#(
    parameter int TOP_FLOOR = 15
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // tdata: dest_floor[7:0], fault_id[15:8], now_ms[47:16]
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: req_type[1:0]
    input  wire logic [S_TUSER_W-1:0] i_s_axis_tuser,
    // tdata: car_floor[3:0], car_motion[5:4], car_mode[7:6], door_open[8],
    //        fault_status[16:9], zero[23:17]
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0]      o_m_axis_tdata,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_index,
    input  wire logic [TIME_W-1:0]    i_cfg_data
);

    t_cfg    cfg;
    t_event  in_event;
    t_event  stage_event;
    t_status core_status;
    t_status out_status;
    logic    stage_valid;
    logic    out_ready;

    assign in_event.req_type   = t_req'(i_s_axis_tuser);
    assign in_event.dest_floor = i_s_axis_tdata[7:0];
    assign in_event.fault_id   = i_s_axis_tdata[15:8];
    assign in_event.now_ms     = i_s_axis_tdata[47:16];

    ecmc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (t_cfg_idx'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ecmc_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_event   (in_event),
        .i_advance (out_ready),
        .o_valid   (stage_valid),
        .o_event   (stage_event)
    );

    ecmc_core #(
        .TOP_FLOOR (TOP_FLOOR)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (stage_valid && out_ready),
        .i_event  (stage_event),
        .i_cfg    (cfg),
        .o_status (core_status)
    );

    ecmc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid),
        .o_ready  (out_ready),
        .i_status (core_status),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_status (out_status)
    );

    assign o_m_axis_tdata = {7'd0, out_status.fault_status, out_status.door_open,
                             out_status.car_mode, out_status.car_motion,
                             out_status.car_floor};

endmodule

`default_nettype wire

>>> hw/rtl/ecmc_checker.sv
// ----------------------------------------------------------------------------
// ecmc_checker
// Port-level checks on the status stream of the car mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

module ecmc_checker
    import ecmc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    input  wire logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    logic [1:0] m_motion;
    logic [1:0] m_mode;
    logic       m_door;
    logic [7:0] m_fault;

    assign m_motion = o_m_axis_tdata[5:4];
    assign m_mode   = o_m_axis_tdata[7:6];
    assign m_door   = o_m_axis_tdata[8];
    assign m_fault  = o_m_axis_tdata[16:9];

    a_rst_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("status valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled status changed");

    a_door_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (m_door == (m_mode == MODE_DOOR)))
        else $error("door state disagrees with mode");

    a_moving_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((m_mode == MODE_MOVING) == (m_motion != MOT_IDLE)))
        else $error("motion disagrees with moving mode");

    a_fault_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && m_fault != 8'd0 |-> m_mode == MODE_FAULT)
        else $error("fault code shown outside fault mode");

endmodule

bind elevator_car_mode_controller ecmc_checker u_ecmc_checker (.*);

`default_nettype wire
